// ----- hw/rtl/tpt_pkg.sv -----
// Shared types and constants for the trapezoid profile tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpt_pkg;

  localparam int TPT_COUNT_BITS = 20;
  localparam int TPT_DIST_BITS  = 32;
  localparam int TPT_ADDR_BITS  = 5;
  localparam int TPT_DATA_BITS  = 32;

  typedef enum logic [2:0] {
    REG_REVERSE     = 3'd0,
    REG_ACCEL_COUNT = 3'd1,
    REG_HOLD_COUNT  = 3'd2,
    REG_DECEL_COUNT = 3'd3,
    REG_ACCEL_INC   = 3'd4,
    REG_DECEL_INC   = 3'd5,
    REG_START_SPEED = 3'd6,
    REG_TARGET      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_ACCEL,
    PH_HOLD,
    PH_DECEL,
    PH_END
  } phase_t;

  typedef struct packed {
    logic        reverse_move;
    logic [19:0] accel_loop_count;
    logic [19:0] hold_loop_count;
    logic [19:0] decel_loop_count;
    logic [23:0] accel_increment;
    logic [23:0] decel_increment;
    logic [23:0] start_speed_step;
    logic [30:0] target_distance;
  } cfg_t;

endpackage

// ----- hw/rtl/tpt_regs.sv -----
// APB configuration registers of the profile tracker.
// Depends on tpt_pkg (cfg_t, register indexes).
`timescale 1ns / 1ps

module tpt_regs import tpt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [TPT_ADDR_BITS-1:0] paddr,
  input  logic [TPT_DATA_BITS-1:0] pwdata,
  output logic [TPT_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_REVERSE:     cfg.reverse_move     <= pwdata[0];
        REG_ACCEL_COUNT: cfg.accel_loop_count <= pwdata[19:0];
        REG_HOLD_COUNT:  cfg.hold_loop_count  <= pwdata[19:0];
        REG_DECEL_COUNT: cfg.decel_loop_count <= pwdata[19:0];
        REG_ACCEL_INC:   cfg.accel_increment  <= pwdata[23:0];
        REG_DECEL_INC:   cfg.decel_increment  <= pwdata[23:0];
        REG_START_SPEED: cfg.start_speed_step <= pwdata[23:0];
        REG_TARGET:      cfg.target_distance  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REVERSE:     prdata = {31'd0, cfg.reverse_move};
      REG_ACCEL_COUNT: prdata = {12'd0, cfg.accel_loop_count};
      REG_HOLD_COUNT:  prdata = {12'd0, cfg.hold_loop_count};
      REG_DECEL_COUNT: prdata = {12'd0, cfg.decel_loop_count};
      REG_ACCEL_INC:   prdata = {8'd0, cfg.accel_increment};
      REG_DECEL_INC:   prdata = {8'd0, cfg.decel_increment};
      REG_START_SPEED: prdata = {8'd0, cfg.start_speed_step};
      REG_TARGET:      prdata = {1'b0, cfg.target_distance};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/tpt_profile.sv -----
// Profile state (phase counters, speed step, setpoint, done) and per-item update.
// Depends on tpt_pkg (cfg_t, phase_t).
`timescale 1ns / 1ps

module tpt_profile import tpt_pkg::*; #(
  parameter int COUNT_BITS = TPT_COUNT_BITS,
  parameter int DIST_BITS  = TPT_DIST_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               action,
  input  logic signed [31:0] left_distance,
  input  logic signed [31:0] right_distance,
  input  cfg_t               cfg,
  output logic signed [31:0] setpoint_next,
  output logic signed [31:0] error_next,
  output logic               done_next
);

  localparam int EW = ((DIST_BITS > 33) ? DIST_BITS : 33) + 2;
  localparam logic signed [EW-1:0] DMAX = EW'((64'sd1 <<< (DIST_BITS - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] DMIN = EW'(-(64'sd1 <<< (DIST_BITS - 1)));

  function automatic logic signed [DIST_BITS-1:0] sat(input logic signed [EW-1:0] v);
    if (v > DMAX) return DMAX[DIST_BITS-1:0];
    if (v < DMIN) return DMIN[DIST_BITS-1:0];
    return v[DIST_BITS-1:0];
  endfunction

  logic [COUNT_BITS-1:0]       accel_left, hold_left, decel_left;
  logic [COUNT_BITS-1:0]       accel_left_next, hold_left_next, decel_left_next;
  logic signed [DIST_BITS-1:0] speed_step, speed_step_next;
  logic signed [DIST_BITS-1:0] position_setpoint, position_setpoint_next;
  logic                        done_flag;

  phase_t              phase;
  logic signed [32:0]  sum;
  logic signed [32:0]  meas;
  logic signed [EW-1:0] meas_x, acc_x, dec_x, start_x, target_x;

  assign sum      = $signed({left_distance[31], left_distance})
                  + $signed({right_distance[31], right_distance});
  assign meas     = sum >>> 1;
  assign meas_x   = cfg.reverse_move ? -EW'(meas) : EW'(meas);
  assign acc_x    = $signed({{(EW-24){1'b0}}, cfg.accel_increment});
  assign dec_x    = $signed({{(EW-24){1'b0}}, cfg.decel_increment});
  assign start_x  = $signed({{(EW-24){1'b0}}, cfg.start_speed_step});
  assign target_x = $signed({{(EW-31){1'b0}}, cfg.target_distance});

  always_comb begin
    if (accel_left != '0)      phase = PH_ACCEL;
    else if (hold_left != '0)  phase = PH_HOLD;
    else if (decel_left != '0) phase = PH_DECEL;
    else                       phase = PH_END;
  end

  always_comb begin
    accel_left_next        = accel_left;
    hold_left_next         = hold_left;
    decel_left_next        = decel_left;
    speed_step_next        = speed_step;
    position_setpoint_next = position_setpoint;
    done_next              = done_flag;
    if (!action) begin
      accel_left_next        = COUNT_BITS'({44'd0, cfg.accel_loop_count});
      hold_left_next         = COUNT_BITS'({44'd0, cfg.hold_loop_count});
      decel_left_next        = COUNT_BITS'({44'd0, cfg.decel_loop_count});
      speed_step_next        = sat(start_x);
      position_setpoint_next = '0;
      done_next              = 1'b0;
    end else begin
      case (phase)
        PH_ACCEL: begin
          accel_left_next = accel_left - COUNT_BITS'(1);
          speed_step_next = sat(EW'(speed_step) + acc_x);
        end
        PH_HOLD: begin
          hold_left_next = hold_left - COUNT_BITS'(1);
        end
        PH_DECEL: begin
          decel_left_next = decel_left - COUNT_BITS'(1);
          speed_step_next = sat(EW'(speed_step) - dec_x);
        end
        default: begin
          done_next = 1'b1;
        end
      endcase
      if (phase == PH_END) position_setpoint_next = sat(target_x);
      else position_setpoint_next = sat(EW'(position_setpoint) + EW'(speed_step_next));
    end
  end

  logic signed [DIST_BITS-1:0] err_d;

  assign err_d         = sat(EW'(position_setpoint_next) - meas_x);
  assign setpoint_next = 32'(position_setpoint_next);
  assign error_next    = 32'(err_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_left        <= '0;
      hold_left         <= '0;
      decel_left        <= '0;
      speed_step        <= '0;
      position_setpoint <= '0;
      done_flag         <= 1'b0;
    end else if (step) begin
      accel_left        <= accel_left_next;
      hold_left         <= hold_left_next;
      decel_left        <= decel_left_next;
      speed_step        <= speed_step_next;
      position_setpoint <= position_setpoint_next;
      done_flag         <= done_next;
    end
  end

endmodule

// ----- hw/rtl/trapezoid_profile_tracker.sv -----
// Top level of the trapezoid profile tracker: input register, profile update, result register.
// Depends on tpt_pkg, tpt_regs and tpt_profile.
`timescale 1ns / 1ps
//
//  channel  handshake                    payload
//  input    in_valid / in_stall          action, left_distance, right_distance
//  result   out_valid / out_stall        setpoint, position_error, move_done
//  config   APB psel/penable/pwrite      paddr[4:2] = register, pwdata, prdata
//
//  Result valid after the input transfer: the input register, then the profile
//  update into the result register.
//  One item per cycle sustained while the result is not stalled; the profile state loop is a single add chain.
//  Reset (rst, synchronous) clears the configuration registers, profile state and both valids.
//  A stalled result holds; the input register still takes one item behind it.

module trapezoid_profile_tracker import tpt_pkg::*; #(
  parameter int COUNT_BITS = TPT_COUNT_BITS,
  parameter int DIST_BITS  = TPT_DIST_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [TPT_ADDR_BITS-1:0] paddr,
  input  logic [TPT_DATA_BITS-1:0] pwdata,
  output logic [TPT_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic signed [31:0]       left_distance,
  input  logic signed [31:0]       right_distance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       setpoint,
  output logic signed [31:0]       position_error,
  output logic                     move_done
);

  cfg_t               cfg;
  logic               s1_valid;
  logic               s1_action;
  logic signed [31:0] s1_left, s1_right;
  logic               advance, step;
  logic signed [31:0] setpoint_next, error_next;
  logic               done_next;

  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  tpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpt_profile #(
    .COUNT_BITS (COUNT_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_profile (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .action         (s1_action),
    .left_distance  (s1_left),
    .right_distance (s1_right),
    .cfg            (cfg),
    .setpoint_next  (setpoint_next),
    .error_next     (error_next),
    .done_next      (done_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action;
      s1_left   <= left_distance;
      s1_right  <= right_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      setpoint       <= setpoint_next;
      position_error <= error_next;
      move_done      <= done_next;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("valids not cleared by reset");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input register dropped a held item");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted transfer not captured");

  a_step_makes_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed item produced no result");

endmodule

// ----- tb/trapezoid_profile_tracker_tb.sv -----
// Self-checking testbench for trapezoid_profile_tracker: directed table, then random moves.
// Programs the profile over APB and checks every result against a table value or a local profile predictor.
// Depends on tpt_pkg and the trapezoid_profile_tracker RTL.
`timescale 1ns / 1ps

module trapezoid_profile_tracker_tb;
  import tpt_pkg::*;

  localparam logic   ACT_START    = 1'b0;
  localparam logic   ACT_TICK     = 1'b1;
  localparam longint DIST_MAX     = 64'sd2147483647;
  localparam longint DIST_MIN     = -64'sd2147483648;
  localparam int     RANDOM_ITEMS = 600;
  localparam int     DIR_ROWS     = 21;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] error;
    logic               done;
  } track_out_t;

  typedef struct packed {
    bit                 reload;
    logic               act;
    logic signed [31:0] left;
    logic signed [31:0] right;
    bit                 typed;
    track_out_t         want;
  } stim_row_t;

  localparam cfg_t RAMP_PROFILE = '{reverse_move: 1'b1, accel_loop_count: 20'd3,
                                    hold_loop_count: 20'd2, decel_loop_count: 20'd2,
                                    accel_increment: 24'h010000, decel_increment: 24'h030000,
                                    start_speed_step: 24'h008000,
                                    target_distance: 31'h7fffffff};

  // rows 0..6 run with registers at reset, the rest with RAMP_PROFILE
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, ACT_TICK,  32'sh00000000, 32'sh00000000, 1'b1, '{32'sh0, 32'sh0, 1'b1}},
    '{1'b0, ACT_TICK,  32'sh7fffffff, 32'sh7fffffff, 1'b1, '{32'sh0, 32'sh80000001, 1'b1}},
    '{1'b0, ACT_TICK,  32'sh80000000, 32'sh80000000, 1'b1, '{32'sh0, 32'sh7fffffff, 1'b1}},
    '{1'b0, ACT_TICK,  32'shffffffff, 32'sh00000000, 1'b1, '{32'sh0, 32'sh1, 1'b1}},
    '{1'b0, ACT_TICK,  32'sh00000001, 32'sh00000000, 1'b1, '{32'sh0, 32'sh0, 1'b1}},
    '{1'b0, ACT_START, 32'sh00000004, 32'sh00000006, 1'b1, '{32'sh0, 32'shfffffffb, 1'b0}},
    '{1'b0, ACT_TICK,  32'sh00000000, 32'sh00000000, 1'b1, '{32'sh0, 32'sh0, 1'b1}},
    '{1'b1, ACT_START, 32'sh00010000, 32'sh00030000, 1'b1, '{32'sh0, 32'sh00020000, 1'b0}},
    '{1'b0, ACT_TICK,  32'sh00001000, 32'sh00003000, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'shfff00000, 32'sh00050000, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh00080000, 32'sh00080001, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh12345678, 32'shedcba987, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh00000003, 32'shfffffffe, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh00200000, 32'sh00100000, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'shfffe0000, 32'shffff0000, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh00000000, 32'sh00000000, 1'b1, '{32'sh7fffffff, 32'sh7fffffff, 1'b1}},
    '{1'b0, ACT_TICK,  32'sh80000000, 32'sh80000000, 1'b1, '{32'sh7fffffff, 32'shffffffff, 1'b1}},
    '{1'b0, ACT_START, 32'sh55555555, 32'shaaaaaaaa, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh00400000, 32'sh00000000, 1'b0, '0},
    '{1'b0, ACT_START, 32'sh7fffffff, 32'sh80000000, 1'b0, '0},
    '{1'b0, ACT_TICK,  32'sh00000000, 32'sh7fffffff, 1'b0, '0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [TPT_ADDR_BITS-1:0] paddr = '0;
  logic [TPT_DATA_BITS-1:0] pwdata = '0;
  logic [TPT_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ACT_TICK;
  logic signed [31:0]       left_distance = '0;
  logic signed [31:0]       right_distance = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [31:0]       setpoint;
  logic signed [31:0]       position_error;
  logic                     move_done;

  trapezoid_profile_tracker u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .left_distance(left_distance), .right_distance(right_distance),
    .out_valid(out_valid), .out_stall(out_stall),
    .setpoint(setpoint), .position_error(position_error), .move_done(move_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // profile predictor state
  cfg_t        prof_cfg = '0;
  logic [19:0] rem_accel = '0;
  logic [19:0] rem_hold = '0;
  logic [19:0] rem_decel = '0;
  longint      cur_speed = 0;
  longint      cur_setpoint = 0;
  logic        cur_done = 1'b0;

  track_out_t  pending_results[$];
  int          fail_count = 0;
  bit          steady = 1'b0;

  function automatic longint clamp_dist(input longint v);
    if (v > DIST_MAX) return DIST_MAX;
    if (v < DIST_MIN) return DIST_MIN;
    return v;
  endfunction

  function automatic track_out_t advance_profile(input logic act,
                                                 input logic signed [31:0] l,
                                                 input logic signed [31:0] r);
    longint     meas;
    track_out_t res;
    meas = (longint'(l) + longint'(r)) >>> 1;
    if (prof_cfg.reverse_move) meas = -meas;
    if (act == ACT_START) begin
      rem_accel    = prof_cfg.accel_loop_count;
      rem_hold     = prof_cfg.hold_loop_count;
      rem_decel    = prof_cfg.decel_loop_count;
      cur_speed    = clamp_dist(longint'(prof_cfg.start_speed_step));
      cur_setpoint = 0;
      cur_done     = 1'b0;
    end else if (rem_accel != 0) begin
      rem_accel--;
      cur_speed    = clamp_dist(cur_speed + longint'(prof_cfg.accel_increment));
      cur_setpoint = clamp_dist(cur_setpoint + cur_speed);
    end else if (rem_hold != 0) begin
      rem_hold--;
      cur_setpoint = clamp_dist(cur_setpoint + cur_speed);
    end else if (rem_decel != 0) begin
      rem_decel--;
      cur_speed    = clamp_dist(cur_speed - longint'(prof_cfg.decel_increment));
      cur_setpoint = clamp_dist(cur_setpoint + cur_speed);
    end else begin
      cur_setpoint = clamp_dist(longint'(prof_cfg.target_distance));
      cur_done     = 1'b1;
    end
    res.setpoint = 32'(cur_setpoint);
    res.error    = 32'(clamp_dist(cur_setpoint - meas));
    res.done     = cur_done;
    return res;
  endfunction

  function automatic logic signed [31:0] pick_distance();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic logic [19:0] pick_count();
    case ($urandom_range(9))
      0: return '0;
      1: return 20'hfffff;
      default: return 20'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [23:0] pick_rate();
    case ($urandom_range(4))
      0: return '0;
      1: return 24'hffffff;
      2: return 24'($urandom);
      default: return 24'($urandom_range(0, 24'h040000));
    endcase
  endfunction

  function automatic cfg_t random_profile(input int phase);
    cfg_t c;
    if (phase == 0) begin
      c = '{1'b1, 20'hfffff, 20'hfffff, 20'hfffff, 24'hffffff, 24'hffffff, 24'hffffff,
            31'h7fffffff};
    end else if (phase == 1) begin
      c = '{1'b0, 20'h0, 20'h0, 20'hfffff, 24'h0, 24'hffffff, 24'h0, 31'h0};
    end else begin
      c.reverse_move     = 1'($urandom_range(1));
      c.accel_loop_count = pick_count();
      c.hold_loop_count  = pick_count();
      c.decel_loop_count = pick_count();
      c.accel_increment  = pick_rate();
      c.decel_increment  = pick_rate();
      c.start_speed_step = pick_rate();
      case ($urandom_range(3))
        0: c.target_distance = '0;
        1: c.target_distance = 31'h7fffffff;
        default: c.target_distance = 31'($urandom);
      endcase
    end
    return c;
  endfunction

  task automatic write_register(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_REVERSE:     prof_cfg.reverse_move     = val[0];
      REG_ACCEL_COUNT: prof_cfg.accel_loop_count = val[19:0];
      REG_HOLD_COUNT:  prof_cfg.hold_loop_count  = val[19:0];
      REG_DECEL_COUNT: prof_cfg.decel_loop_count = val[19:0];
      REG_ACCEL_INC:   prof_cfg.accel_increment  = val[23:0];
      REG_DECEL_INC:   prof_cfg.decel_increment  = val[23:0];
      REG_START_SPEED: prof_cfg.start_speed_step = val[23:0];
      REG_TARGET:      prof_cfg.target_distance  = val[30:0];
      default: ;
    endcase
  endtask

  task automatic load_registers(input cfg_t c);
    reg_idx_t    idx;
    logic [31:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_REVERSE:     val = 32'(c.reverse_move);
        REG_ACCEL_COUNT: val = 32'(c.accel_loop_count);
        REG_HOLD_COUNT:  val = 32'(c.hold_loop_count);
        REG_DECEL_COUNT: val = 32'(c.decel_loop_count);
        REG_ACCEL_INC:   val = 32'(c.accel_increment);
        REG_DECEL_INC:   val = 32'(c.decel_increment);
        REG_START_SPEED: val = 32'(c.start_speed_step);
        default:         val = 32'(c.target_distance);
      endcase
      write_register(idx, val);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic act, input logic signed [31:0] l,
                           input logic signed [31:0] r, input bit typed,
                           input track_out_t want);
    track_out_t res;
    if (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    left_distance  <= l;
    right_distance <= r;
    do @(posedge clk); while (in_stall);
    res = advance_profile(act, l, r);
    pending_results.push_back(typed ? want : res);
  endtask

  // drain the pipeline: wait for the last expected result, then let the bench idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    track_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected transfer: setpoint %h error %h done %b",
                   setpoint, position_error, move_done);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (setpoint !== want.setpoint || position_error !== want.error ||
            move_done !== want.done) begin
          if (fail_count < 10)
            $display("mismatch: setpoint %h/%h error %h/%h done %b/%b (exp/got)",
                     want.setpoint, setpoint, want.error, position_error,
                     want.done, move_done);
          fail_count++;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 17);
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int   random_sent;
    int   phase;
    int   moves;
    int   span;
    int   ticks;
    logic act;
    random_sent = 0;
    phase       = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].reload) begin
        wait_idle();
        load_registers(RAMP_PROFILE);
      end
      send_item(DIR_TABLE[i].act, DIR_TABLE[i].left, DIR_TABLE[i].right,
                DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      load_registers(random_profile(phase));
      steady = (phase == 3);
      moves  = (phase < 2 || steady) ? 1 : $urandom_range(2, 4);
      repeat (moves) begin
        span = int'(prof_cfg.accel_loop_count) + int'(prof_cfg.hold_loop_count) +
               int'(prof_cfg.decel_loop_count);
        if (phase < 2) ticks = 140;
        else if (steady) ticks = 100;
        else if (span > 40) ticks = $urandom_range(10, 40);
        else ticks = span + $urandom_range(0, 3);
        send_item(ACT_START, pick_distance(), pick_distance(), 1'b0, '0);
        random_sent++;
        repeat (ticks) begin
          // occasional stray start breaks the move
          act = ($urandom_range(99) < 6) ? 1'($urandom_range(1)) : ACT_TICK;
          send_item(act, pick_distance(), pick_distance(), 1'b0, '0);
          random_sent++;
        end
      end
      phase++;
    end
    steady = 1'b0;
    wait_idle();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
